>>> design/substring_search_all_matches_unit_defines.svh
// Assertion macros shared by the checker of the substring search unit.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef SUBSTRING_SEARCH_ALL_MATCHES_UNIT_DEFINES_SVH
`define SUBSTRING_SEARCH_ALL_MATCHES_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define SSAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define SSAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ssam_pkg.sv
// Package for the substring search unit: request/result structs, sizes, codes.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ssam_pkg;

    // Size bounds
    localparam int MAX_PATTERN = 32;
    localparam int MAX_TEXT    = 256;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int POS_W       = $clog2(MAX_TEXT + 1);

    // Result queue
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int LVL_W       = $clog2(FIFO_DEPTH + 1);

    // Codes
    localparam logic       CMD_PATTERN  = 1'b0;
    localparam logic       CMD_TEXT     = 1'b1;
    localparam logic       KIND_MATCH   = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam logic [7:0] NUL_BYTE     = 8'h00;
    localparam logic [7:0] COUNT_MAX    = 8'hFF;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] position;
        logic       found;
        logic [7:0] match_count;
        logic       overflow;
        logic       final_item;
    } result_t;

    // Broadcast control for the cell chain
    typedef struct packed {
        logic       clear;
        logic       shift;
        logic [7:0] data_byte;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/substring_search_all_matches_unit.sv
// Top level of the substring search unit: pattern/text control, cell chain, result queue.
// Depends on ssam_pkg, ssam_cell and ssam_result_fifo.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------
//   requests | item_valid    | item_stall    | item   (item_t)
//   results  | result_valid  | result_stall  | result (result_t)
//
// One request per cycle; a text byte is matched against the whole pattern in the
// cycle it is taken, since each cell of the chain checks its own pattern byte.
// A text byte gives at most two results (match report, summary) into a 4-entry queue;
// requests stall only while that queue holds more than two results.
// Results are held in the registered result queue. Reset is asynchronous and needs no sweep.
`default_nettype none

module substring_search_all_matches_unit import ssam_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       first_reg, first_next;
    logic             found_reg, found_next;
    logic [7:0]       count_reg, count_next;
    logic             complete_reg, complete_next;
    logic             pat_ovf_reg, pat_ovf_next;
    logic             txt_ovf_reg, txt_ovf_next;

    logic             accept, is_text, nonzero, restart, text_eos, pop;
    logic [LEN_W-1:0] len_eff;
    cell_ctl_t        ctl;
    logic [MAX_PATTERN-1:0] load_vec, last_vec, hit_now_vec, hit_vec, prev_vec;
    logic             hit, empty_pat, ovf_out;
    logic [POS_W-1:0] pos_inc, pos_upd;
    logic [7:0]       start, cnt_hit, first_upd, count_upd, cnt_empty;
    logic             found_upd, txt_ovf_upd;
    result_t          match_rpt, summary;
    logic [1:0]       push_n;
    logic [LVL_W-1:0] level;

    // Request handshake
    assign accept     = item_valid && !item_stall;
    assign item_stall = (level > LVL_W'(FIFO_DEPTH - 2));
    assign is_text    = (item.cmd == CMD_TEXT);
    assign nonzero    = (item.data_byte != NUL_BYTE);
    assign restart    = accept && !is_text && complete_reg;
    assign text_eos   = accept && is_text && item.end_of_string;
    assign len_eff    = restart ? '0 : len_reg;

    // Broadcast to the chain
    assign ctl.clear     = restart || text_eos;
    assign ctl.shift     = accept && is_text && nonzero && (pos_reg < POS_W'(MAX_TEXT));
    assign ctl.data_byte = item.data_byte;

    // Cell chain: cell k holds pattern byte k
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        assign load_vec[k] = accept && !is_text && nonzero && (len_eff == LEN_W'(k));
        assign last_vec[k] = (len_reg == LEN_W'(k + 1));
        if (k == 0)
        begin : g_head
            assign prev_vec[k] = 1'b1;
        end
        else
        begin : g_body
            assign prev_vec[k] = hit_vec[k-1];
        end
        ssam_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .load     (load_vec[k]),
            .prev_hit (prev_vec[k]),
            .hit_now  (hit_now_vec[k]),
            .hit      (hit_vec[k])
        );
    end

    // Match detection and updated text statistics
    assign hit         = ctl.shift && (len_reg != '0) && !pat_ovf_reg
                         && ((hit_now_vec & last_vec) != '0);
    assign pos_inc     = pos_reg + POS_W'(1);
    assign pos_upd     = ctl.shift ? pos_inc : pos_reg;
    assign start       = 8'(pos_inc - POS_W'(len_reg));
    assign cnt_hit     = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign found_upd   = found_reg || hit;
    assign first_upd   = (hit && !found_reg) ? start : first_reg;
    assign count_upd   = hit ? cnt_hit : count_reg;
    assign txt_ovf_upd = txt_ovf_reg
                         || (accept && is_text && nonzero && (pos_reg >= POS_W'(MAX_TEXT)));
    assign ovf_out     = pat_ovf_reg || txt_ovf_upd;
    assign empty_pat   = (len_reg == '0) && !pat_ovf_reg;
    assign cnt_empty   = (pos_upd >= POS_W'(COUNT_MAX)) ? COUNT_MAX : 8'(pos_upd) + 8'd1;

    // Result records
    always_comb
    begin
        match_rpt.kind        = KIND_MATCH;
        match_rpt.position    = start;
        match_rpt.found       = 1'b1;
        match_rpt.match_count = cnt_hit;
        match_rpt.overflow    = ovf_out;
        match_rpt.final_item  = !item.end_of_string;

        summary.kind          = KIND_SUMMARY;
        summary.position      = empty_pat ? 8'd0 : (found_upd ? first_upd : 8'd0);
        summary.found         = empty_pat ? 1'b1 : found_upd;
        summary.match_count   = empty_pat ? cnt_empty : count_upd;
        summary.overflow      = ovf_out;
        summary.final_item    = 1'b1;
    end

    assign push_n = 2'(hit) + 2'(text_eos);
    assign pop    = result_valid && !result_stall;

    ssam_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .entry0    (hit ? match_rpt : summary),
        .entry1    (summary),
        .pop       (pop),
        .not_empty (result_valid),
        .head      (result),
        .level     (level)
    );

    // Pattern and text state
    always_comb
    begin
        len_next      = len_reg;
        pos_next      = pos_reg;
        first_next    = first_reg;
        found_next    = found_reg;
        count_next    = count_reg;
        complete_next = complete_reg;
        pat_ovf_next  = pat_ovf_reg;
        txt_ovf_next  = txt_ovf_reg;
        if (accept && !is_text)
        begin
            len_next     = len_eff + LEN_W'(nonzero && (len_eff < LEN_W'(MAX_PATTERN)));
            pat_ovf_next = (restart ? 1'b0 : pat_ovf_reg)
                           || (nonzero && (len_eff >= LEN_W'(MAX_PATTERN)));
            complete_next = item.end_of_string || (restart ? 1'b0 : complete_reg);
            if (restart)
            begin
                pos_next     = '0;
                first_next   = '0;
                found_next   = 1'b0;
                count_next   = '0;
                txt_ovf_next = 1'b0;
            end
        end
        else if (accept)
        begin
            complete_next = 1'b1;
            if (item.end_of_string)
            begin
                pos_next     = '0;
                first_next   = '0;
                found_next   = 1'b0;
                count_next   = '0;
                txt_ovf_next = 1'b0;
            end
            else
            begin
                pos_next     = pos_upd;
                first_next   = first_upd;
                found_next   = found_upd;
                count_next   = count_upd;
                txt_ovf_next = txt_ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            pos_reg      <= '0;
            first_reg    <= '0;
            found_reg    <= 1'b0;
            count_reg    <= '0;
            complete_reg <= 1'b0;
            pat_ovf_reg  <= 1'b0;
            txt_ovf_reg  <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            first_reg    <= first_next;
            found_reg    <= found_next;
            count_reg    <= count_next;
            complete_reg <= complete_next;
            pat_ovf_reg  <= pat_ovf_next;
            txt_ovf_reg  <= txt_ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> design/ssam_cell.sv
// One cell of the matcher chain: a pattern byte and a partial-match bit.
// Depends on ssam_pkg.
`default_nettype none

module ssam_cell import ssam_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      load,
    input  wire logic      prev_hit,
    output logic           hit_now,
    output logic           hit
);

    logic [7:0] pat_byte_reg;
    logic       hit_reg;
    logic       hit_next;

    // Pattern byte, written once per pattern
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pat_byte_reg <= ctl.data_byte;
        end
    end

    // Prefix of length index+1 ends at the incoming byte
    assign hit_now = prev_hit && (ctl.data_byte == pat_byte_reg);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            hit_next = hit_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

>>> design/ssam_result_fifo.sv
// Small result queue: takes up to two results per cycle, gives one.
// Depends on ssam_pkg.
`default_nettype none

module ssam_result_fifo import ssam_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic [1:0] push_n,
    input  wire result_t entry0,
    input  wire result_t entry1,
    input  wire logic    pop,
    output logic         not_empty,
    output result_t      head,
    output logic [LVL_W-1:0] level
);

    result_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]     level_reg, level_next;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= entry0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= entry1;
        end
    end

    // Pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LVL_W'(push_n) - LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign not_empty = (level_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign level     = level_reg;

endmodule

`default_nettype wire

>>> design/ssam_checker.sv
// Port-level checker for the substring search unit, bound to the top level.
// Depends on ssam_pkg and substring_search_all_matches_unit_defines.svh.
`default_nettype none

`include "substring_search_all_matches_unit_defines.svh"

module ssam_checker import ssam_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_stall,
    input  wire item_t   item,
    input  wire logic    result_valid,
    input  wire logic    result_stall,
    input  wire result_t result
);

    // A held result keeps its contents
    `SSAM_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

    // A result never shows up without a request taken the cycle before
    `SSAM_ASSERT_IMP(a_no_phantom, $rose(result_valid), $past(item_valid && !item_stall), "result without a request")

    // Summaries close their request; match reports always say found
    `SSAM_ASSERT_IMP(a_result_shape, result_valid, (result.kind == KIND_SUMMARY) ? result.final_item : result.found, "malformed result")

    // A pattern byte yields nothing: no new result after a pattern request into an empty queue
    `SSAM_ASSERT_NXT(a_pattern_silent, item_valid && !item_stall && (item.cmd == CMD_PATTERN) && !result_valid, !result_valid, "pattern request gave a result")

endmodule

bind substring_search_all_matches_unit ssam_checker u_ssam_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for substring_search_all_matches_unit: random and directed requests,
// with every result compared against an in-bench search model.
// Depends on ssam_pkg and the substring_search_all_matches_unit RTL.
`default_nettype none

module tb_top;
    import ssam_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    result_stall = 1'b0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    substring_search_all_matches_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Search model state
    logic [7:0]  pat_bytes [MAX_PATTERN];
    int unsigned pat_len;
    bit          pat_closed;
    bit          pat_ovf;
    logic [7:0]  text_win [MAX_PATTERN];
    int unsigned text_len;
    logic [7:0]  first_hit;
    bit          any_hit;
    int unsigned hit_count;
    bit          text_ovf;

    result_t     pending_reports [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          idle_cycles    = 0;
    int          send_calm      = 0;
    int          take_calm      = 0;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_text_state();
        foreach (text_win[i])
            text_win[i] = 8'h00;
        text_len  = 0;
        first_hit = 8'h00;
        any_hit   = 1'b0;
        hit_count = 0;
        text_ovf  = 1'b0;
    endfunction

    function automatic result_t make_result(logic kind, logic [7:0] pos, logic fnd,
                                            logic [7:0] cnt);
        result_t r;
        r.kind        = kind;
        r.position    = pos;
        r.found       = fnd;
        r.match_count = cnt;
        r.overflow    = pat_ovf || text_ovf;
        r.final_item  = 1'b0;
        return r;
    endfunction

    // Advance the search model by one request and queue the results it causes
    function automatic void search_step(item_t it);
        result_t     batch [$];
        int unsigned start;
        bit          hit;
        if (it.cmd == CMD_PATTERN)
        begin
            // a pattern byte after a closed pattern starts over
            if (pat_closed)
            begin
                pat_len    = 0;
                pat_ovf    = 1'b0;
                pat_closed = 1'b0;
                clear_text_state();
            end
            if (it.data_byte != NUL_BYTE)
            begin
                if (pat_len < MAX_PATTERN)
                begin
                    pat_bytes[pat_len] = it.data_byte;
                    pat_len++;
                end
                else
                    pat_ovf = 1'b1;
            end
            if (it.end_of_string)
                pat_closed = 1'b1;
            return;
        end

        pat_closed = 1'b1;
        if (it.data_byte != NUL_BYTE)
        begin
            if (text_len >= MAX_TEXT)
                text_ovf = 1'b1;
            else
            begin
                text_win[text_len % MAX_PATTERN] = it.data_byte;
                text_len++;
                if (pat_len > 0 && !pat_ovf && text_len >= pat_len)
                begin
                    start = text_len - pat_len;
                    hit   = 1'b1;
                    for (int k = 0; k < pat_len; k++)
                        if (text_win[(start + k) % MAX_PATTERN] != pat_bytes[k])
                            hit = 1'b0;
                    if (hit)
                    begin
                        if (!any_hit)
                        begin
                            any_hit   = 1'b1;
                            first_hit = 8'(start);
                        end
                        if (hit_count < 255)
                            hit_count++;
                        batch.push_back(make_result(KIND_MATCH, 8'(start), 1'b1,
                                                    8'(hit_count)));
                    end
                end
            end
        end

        // end of text: summary, then text state goes back to reset
        if (it.end_of_string)
        begin
            if (pat_len == 0 && !pat_ovf)
                batch.push_back(make_result(KIND_SUMMARY, 8'h00, 1'b1,
                                            (text_len + 1 > 255) ? COUNT_MAX
                                                                 : 8'(text_len + 1)));
            else
                batch.push_back(make_result(KIND_SUMMARY, any_hit ? first_hit : 8'h00,
                                            any_hit, 8'(hit_count)));
            clear_text_state();
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].final_item = 1'b1;
        foreach (batch[i])
            pending_reports.push_back(batch[i]);
    endfunction

    // Wait before a request or a result; now and then a run with no waits at all
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic item_t req(logic cmd, logic [7:0] b, logic eos);
        item_t it;
        it.cmd           = cmd;
        it.data_byte     = b;
        it.end_of_string = eos;
        return it;
    endfunction

    // Send one request: optional gap, then hold it until taken
    task automatic send_item(item_t it);
        int gap;
        gap = draw_wait(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        search_step(it);
        items_sent++;
    endtask

    task automatic send_string(logic cmd, logic [7:0] s [$], bit close);
        foreach (s[i])
            send_item(req(cmd, s[i], close && (i == s.size() - 1)));
    endtask

    // Hold off requests until every expected result has come back
    task automatic wait_for_quiet();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 19))
            0:       return 8'($urandom_range(1, 255));
            1:       return NUL_BYTE;
            default: return $urandom_range(0, 1) ? sym_a : sym_b;
        endcase
    endfunction

    // Empty pattern, simple and overlapping matches, zero bytes, pattern restarts
    task automatic test_directed();
        // empty pattern, then a two-byte text and an empty text
        send_item(req(CMD_PATTERN, NUL_BYTE, 1'b1));
        send_item(req(CMD_TEXT, 8'h61, 1'b0));
        send_item(req(CMD_TEXT, 8'hFF, 1'b1));
        send_item(req(CMD_TEXT, NUL_BYTE, 1'b1));
        // two-byte pattern, two matches, text closed by a zero byte
        send_item(req(CMD_PATTERN, 8'h80, 1'b0));
        send_item(req(CMD_PATTERN, 8'h01, 1'b1));
        send_item(req(CMD_TEXT, 8'h80, 1'b0));
        send_item(req(CMD_TEXT, 8'h01, 1'b0));
        send_item(req(CMD_TEXT, 8'h80, 1'b0));
        send_item(req(CMD_TEXT, 8'h01, 1'b0));
        send_item(req(CMD_TEXT, NUL_BYTE, 1'b1));
        // pattern left open and closed by the first text byte; overlapping matches
        send_item(req(CMD_PATTERN, 8'hFF, 1'b0));
        send_item(req(CMD_PATTERN, 8'hFF, 1'b0));
        send_item(req(CMD_TEXT, 8'hFF, 1'b0));
        send_item(req(CMD_TEXT, 8'hFF, 1'b0));
        send_item(req(CMD_TEXT, 8'hFF, 1'b1));
        // new pattern in the middle of a text drops the text
        send_item(req(CMD_TEXT, 8'h7F, 1'b0));
        send_item(req(CMD_PATTERN, 8'h7F, 1'b1));
        send_item(req(CMD_TEXT, 8'h7F, 1'b1));
        // zero byte inside a pattern is skipped
        send_item(req(CMD_PATTERN, NUL_BYTE, 1'b0));
        send_item(req(CMD_PATTERN, 8'h55, 1'b0));
        send_item(req(CMD_PATTERN, 8'hAA, 1'b1));
        send_item(req(CMD_TEXT, 8'hAA, 1'b1));
    endtask

    // Pattern past the bound never matches; a full-size pattern matches across the wrap
    task automatic test_long_pattern();
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        repeat (MAX_PATTERN + 1)
            pat.push_back(8'($urandom_range(1, 255)));
        send_string(CMD_PATTERN, pat, 1'b1);
        txt = pat[0:MAX_PATTERN - 1];
        send_string(CMD_TEXT, txt, 1'b1);
        send_item(req(CMD_TEXT, NUL_BYTE, 1'b1));

        pat.delete();
        txt.delete();
        repeat (MAX_PATTERN)
            pat.push_back(8'($urandom_range(1, 255)));
        send_string(CMD_PATTERN, pat, 1'b1);
        repeat (5)
            txt.push_back(8'($urandom_range(1, 255)));
        foreach (pat[i])
            txt.push_back(pat[i]);
        send_string(CMD_TEXT, txt, 1'b1);
    endtask

    // Text past the bound, match count saturation, empty-pattern count reaching its maximum
    task automatic test_long_text();
        logic [7:0] txt [$];
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        send_item(req(CMD_PATTERN, c, 1'b1));
        repeat (MAX_TEXT + 2)
            txt.push_back(c);
        send_string(CMD_TEXT, txt, 1'b1);

        txt.delete();
        send_item(req(CMD_PATTERN, NUL_BYTE, 1'b1));
        repeat (254)
            txt.push_back(8'($urandom_range(1, 255)));
        send_string(CMD_TEXT, txt, 1'b1);
    endtask

    // Mostly well-formed pattern/text sequences over a small alphabet, with some noise
    task automatic test_random_searches();
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        int         base;
        int         plen;
        int         tlen;
        int         close_mode;
        base = items_sent;
        while (items_sent - base < 50)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: fully random requests
                repeat ($urandom_range(1, 4))
                    send_item(req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 3) == 0));
                continue;
            end

            // new pattern most of the time, else reuse the current one
            if ($urandom_range(0, 2) != 0)
            begin
                sym_a = 8'($urandom_range(1, 255));
                sym_b = $urandom_range(0, 3) == 0 ? sym_a : 8'($urandom_range(1, 255));
                plen  = $urandom_range(0, 7) == 0 ? $urandom_range(20, MAX_PATTERN)
                                                  : $urandom_range(0, 5);
                pat.delete();
                while (pat.size() < plen)
                    pat.push_back($urandom_range(0, 1) ? sym_a : sym_b);
                close_mode = (plen == 0) ? 1 : $urandom_range(0, 2);
                send_string(CMD_PATTERN, pat, close_mode == 0);
                if (close_mode == 1)
                    send_item(req(CMD_PATTERN, NUL_BYTE, 1'b1));
            end

            // text with planted copies of the pattern
            tlen = $urandom_range(0, 7) == 0 ? $urandom_range(40, 80) : $urandom_range(0, 30);
            txt.delete();
            while (txt.size() < tlen)
            begin
                if (pat.size() > 0 && $urandom_range(0, 3) == 0)
                    foreach (pat[i])
                        txt.push_back(pat[i]);
                else
                    txt.push_back(pick_symbol());
            end
            close_mode = (tlen == 0) ? 1 : $urandom_range(0, 9);
            if (close_mode == 9)
                send_string(CMD_TEXT, txt, 1'b0);
            else
            begin
                send_string(CMD_TEXT, txt, close_mode != 1);
                if (close_mode == 1)
                    send_item(req(CMD_TEXT, NUL_BYTE, 1'b1));
            end
        end
    endtask

    // Result side stall pattern
    initial
    begin
        int n;
        forever
        begin
            n = draw_wait(take_calm);
            if (n > 0)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(rst_n && result_valid && !result_stall));
        end
    end

    // Compare each taken result with the oldest expected one
    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"unexpected result: kind=%0d pos=%0d found=%0d cnt=%0d",
                              " ovf=%0d last=%0d"},
                             result.kind, result.position, result.found,
                             result.match_count, result.overflow, result.final_item);
            end
            else
            begin
                exp = pending_reports.pop_front();
                if (result.kind !== exp.kind || result.position !== exp.position ||
                    result.found !== exp.found || result.match_count !== exp.match_count ||
                    result.overflow !== exp.overflow || result.final_item !== exp.final_item)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: exp kind=%0d pos=%0d found=%0d",
                                  " cnt=%0d ovf=%0d last=%0d | got kind=%0d pos=%0d",
                                  " found=%0d cnt=%0d ovf=%0d last=%0d"},
                                 exp.kind, exp.position, exp.found, exp.match_count,
                                 exp.overflow, exp.final_item,
                                 result.kind, result.position, result.found,
                                 result.match_count, result.overflow, result.final_item);
                end
            end
        end
    end

    // Watchdog: too long without any request or result taken
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[substring_search_all_matches_unit] ERROR");
        $finish;
    end

    // Test sequence
    initial
    begin
        pat_len    = 0;
        pat_closed = 1'b0;
        pat_ovf    = 1'b0;
        foreach (pat_bytes[i])
            pat_bytes[i] = 8'h00;
        clear_text_state();
        sym_a = 8'h01;
        sym_b = 8'h02;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_for_quiet();
        test_long_pattern();
        wait_for_quiet();
        test_long_text();
        test_random_searches();

        // drain, then let any stray result show up
        wait_for_quiet();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("[substring_search_all_matches_unit] OK");
        else
            $display("[substring_search_all_matches_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
